>>> design/rfl_pkg.sv
// Shared widths, result types and helper functions for the vector reflection block.
// Every module of the block imports this package. It depends on nothing else.
package rfl_pkg;

    // Width of one input component.
    localparam int CW = 16;
    // Width of one reflected component.
    localparam int OW = CW + 1;
    // Width of a product of two magnitudes.
    localparam int PW = 2 * CW - 1;
    // Width of a sum of three products. This covers the dot product and n.n.
    localparam int SW = 2 * CW;
    // Width of the numerator 2 |v.n| |n_i|.
    localparam int NW = SW + CW + 1;
    // Width of the quotient. It is bounded by twice the length of v.
    localparam int QW = CW + 1;
    // Width of the signed sum v_i +/- q before it is clamped.
    localparam int RW = CW + 3;

    typedef logic signed [CW-1:0] comp_t;
    typedef logic [CW-1:0]        cmag_t;
    typedef logic [SW-1:0]        sum_t;
    typedef logic [NW-1:0]        num_t;
    typedef logic [QW-1:0]        quot_t;

    // Magnitude of a two's complement component. The most negative value maps to 2^(CW-1).
    function automatic cmag_t mag(input comp_t x);
        cmag_t m;
        m = x[CW-1] ? (~cmag_t'(x) + cmag_t'(1)) : cmag_t'(x);
        return m;
    endfunction

endpackage

>>> design/vector_reflection_about_normal.sv
// Reflection of a 3D vector about a mirror normal: r = v - 2 (v.n) n / (n.n).
// Top level: dot products, scaling, divider, then rounding and the output register.
// It depends on rfl_pkg, rfl_dot, rfl_scale and rfl_div.
//
// Usage:
//   The input channel carries one item per handshake: vec_x/y/z and norm_x/y/z, signed.
//   The output channel returns one item per input item, in order: refl_x/y/z, whose
//   quotient term is rounded to nearest with ties away from zero, and zero_normal.
//   For a zero normal the components are zero and zero_normal is set.
//   From acceptance to out_valid an item passes two stages of products and sums, two of
//   sign and scaling, one per quotient bit in the divider, one for rounding and one output
//   register. Throughput is one item per cycle while out_ready stays high; the divider
//   is fully pipelined.
//   Every stage holds its item while the stage after it is full and stalled, so when
//   out_ready is low the pipeline fills up and in_ready falls once no stage is free.
//   No item is lost or repeated across a stall.
//   Reset clears all valid bits; the block keeps no state between items.
module vector_reflection_about_normal
    import rfl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] vec_x,
    input  logic signed [CW-1:0] vec_y,
    input  logic signed [CW-1:0] vec_z,
    input  logic signed [CW-1:0] norm_x,
    input  logic signed [CW-1:0] norm_y,
    input  logic signed [CW-1:0] norm_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [OW-1:0] refl_x,
    output logic signed [OW-1:0] refl_y,
    output logic signed [OW-1:0] refl_z,
    output logic                 zero_normal
);

    comp_t vec_in [3];
    comp_t norm_in [3];

    logic  d_valid;
    logic  d_ready;
    comp_t d_vec [3];
    cmag_t d_nmag [3];
    logic  d_nneg [3];
    sum_t  d_pos;
    sum_t  d_neg;
    sum_t  d_nn;

    logic  s_valid;
    logic  s_ready;
    comp_t s_vec [3];
    num_t  s_num [3];
    logic  s_sub [3];
    sum_t  s_nn;
    logic  s_zero;

    logic  q_valid;
    logic  q_ready;
    comp_t q_vec [3];
    quot_t q_quot [3];
    sum_t  q_rem [3];
    logic  q_sub [3];
    sum_t  q_nn;
    logic  q_zero;

    logic [1:0] vld_reg;
    logic [2:0] rdy;

    comp_t rv_reg [3];
    quot_t rq_reg [3];
    logic  rsub_reg [3];
    logic  rzero_reg;

    logic signed [OW-1:0] out_reg [3];
    logic                 zero_reg;

    quot_t                rq_next [3];
    logic signed [RW-1:0] sum_next [3];
    logic signed [OW-1:0] out_next [3];

    assign vec_in[0]  = vec_x;
    assign vec_in[1]  = vec_y;
    assign vec_in[2]  = vec_z;
    assign norm_in[0] = norm_x;
    assign norm_in[1] = norm_y;
    assign norm_in[2] = norm_z;

    rfl_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .vec       (vec_in),
        .norm      (norm_in),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .vec_out   (d_vec),
        .nmag_out  (d_nmag),
        .nneg_out  (d_nneg),
        .pos_out   (d_pos),
        .neg_out   (d_neg),
        .nn_out    (d_nn)
    );

    rfl_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .vec       (d_vec),
        .nmag      (d_nmag),
        .nneg      (d_nneg),
        .pos       (d_pos),
        .neg       (d_neg),
        .nn        (d_nn),
        .out_valid (s_valid),
        .out_ready (s_ready),
        .vec_out   (s_vec),
        .num_out   (s_num),
        .sub_out   (s_sub),
        .nn_out    (s_nn),
        .zero_out  (s_zero)
    );

    rfl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .vec       (s_vec),
        .num       (s_num),
        .sub       (s_sub),
        .nn        (s_nn),
        .zero      (s_zero),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .vec_out   (q_vec),
        .quot_out  (q_quot),
        .rem_out   (q_rem),
        .sub_out   (q_sub),
        .nn_out    (q_nn),
        .zero_out  (q_zero)
    );

    assign rdy[2]  = out_ready;
    assign rdy[1]  = ~vld_reg[1] | rdy[2];
    assign rdy[0]  = ~vld_reg[0] | rdy[1];
    assign q_ready = rdy[0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // Round up when twice the remainder reaches the divisor; ties go away from zero.
            rq_next[i] = q_quot[i] + quot_t'({q_rem[i], 1'b0} >= {1'b0, q_nn});

            if (rsub_reg[i])
                sum_next[i] = RW'(rv_reg[i]) - RW'($signed({1'b0, rq_reg[i]}));
            else
                sum_next[i] = RW'(rv_reg[i]) + RW'($signed({1'b0, rq_reg[i]}));

            // Saturate when the top bits are not all copies of the output sign bit.
            if (rzero_reg)
                out_next[i] = '0;
            else if (sum_next[i][RW-1:OW-1] == '0 || sum_next[i][RW-1:OW-1] == '1)
                out_next[i] = sum_next[i][OW-1:0];
            else if (sum_next[i][RW-1])
                out_next[i] = {1'b1, {(OW-1){1'b0}}};
            else
                out_next[i] = {1'b0, {(OW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[0])
                vld_reg[0] <= q_valid;
            if (rdy[1])
                vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            rv_reg    <= q_vec;
            rq_reg    <= rq_next;
            rsub_reg  <= q_sub;
            rzero_reg <= q_zero;
        end
        if (rdy[1])
        begin
            out_reg  <= out_next;
            zero_reg <= rzero_reg;
        end
    end

    assign out_valid   = vld_reg[1];
    assign refl_x      = out_reg[0];
    assign refl_y      = out_reg[1];
    assign refl_z      = out_reg[2];
    assign zero_normal = zero_reg;

endmodule

>>> design/rfl_dot.sv
// Front end of the reflection pipeline: component magnitudes, products and three-term sums.
// It has two register stages and produces the positive and negative parts of v.n and n.n.
// It depends on rfl_pkg.
module rfl_dot
    import rfl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  comp_t vec [3],
    input  comp_t norm [3],
    output logic  out_valid,
    input  logic  out_ready,
    output comp_t vec_out [3],
    output cmag_t nmag_out [3],
    output logic  nneg_out [3],
    output sum_t  pos_out,
    output sum_t  neg_out,
    output sum_t  nn_out
);

    logic [1:0] vld_reg;
    logic [2:0] rdy;

    // Stage one: products of magnitudes.
    comp_t            v1_reg [3];
    cmag_t            nm1_reg [3];
    logic             nneg1_reg [3];
    logic [PW-1:0]    pv1_reg [3];
    logic [PW-1:0]    pn1_reg [3];
    logic             pneg1_reg [3];

    // Stage two: sums.
    comp_t            v2_reg [3];
    cmag_t            nm2_reg [3];
    logic             nneg2_reg [3];
    sum_t             pos2_reg;
    sum_t             neg2_reg;
    sum_t             nn2_reg;

    cmag_t            vm_next [3];
    cmag_t            nm_next [3];
    sum_t             pos_next;
    sum_t             neg_next;
    sum_t             nn_next;

    assign rdy[2]   = out_ready;
    assign rdy[1]   = ~vld_reg[1] | rdy[2];
    assign rdy[0]   = ~vld_reg[0] | rdy[1];
    assign in_ready = rdy[0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vm_next[i] = mag(vec[i]);
            nm_next[i] = mag(norm[i]);
        end
        pos_next = '0;
        neg_next = '0;
        nn_next  = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (pneg1_reg[i])
                neg_next = neg_next + SW'(pv1_reg[i]);
            else
                pos_next = pos_next + SW'(pv1_reg[i]);
            nn_next = nn_next + SW'(pn1_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            if (rdy[1])
                vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                v1_reg[i]    <= vec[i];
                nm1_reg[i]   <= nm_next[i];
                nneg1_reg[i] <= norm[i][CW-1];
                pv1_reg[i]   <= PW'(vm_next[i]) * PW'(nm_next[i]);
                pn1_reg[i]   <= PW'(nm_next[i]) * PW'(nm_next[i]);
                pneg1_reg[i] <= vec[i][CW-1] ^ norm[i][CW-1];
            end
        end
        if (rdy[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                v2_reg[i]    <= v1_reg[i];
                nm2_reg[i]   <= nm1_reg[i];
                nneg2_reg[i] <= nneg1_reg[i];
            end
            pos2_reg <= pos_next;
            neg2_reg <= neg_next;
            nn2_reg  <= nn_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign vec_out   = v2_reg;
    assign nmag_out  = nm2_reg;
    assign nneg_out  = nneg2_reg;
    assign pos_out   = pos2_reg;
    assign neg_out   = neg2_reg;
    assign nn_out    = nn2_reg;

endmodule

>>> design/rfl_scale.sv
// Signed dot product and the numerators 2 |v.n| |n_i| of the three quotients.
// Two register stages: difference and sign, then one multiplier per lane.
// It depends on rfl_pkg.
module rfl_scale
    import rfl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  comp_t vec [3],
    input  cmag_t nmag [3],
    input  logic  nneg [3],
    input  sum_t  pos,
    input  sum_t  neg,
    input  sum_t  nn,
    output logic  out_valid,
    input  logic  out_ready,
    output comp_t vec_out [3],
    output num_t  num_out [3],
    output logic  sub_out [3],
    output sum_t  nn_out,
    output logic  zero_out
);

    logic [1:0] vld_reg;
    logic [2:0] rdy;

    comp_t v1_reg [3];
    cmag_t nm1_reg [3];
    logic  nneg1_reg [3];
    sum_t  dmag1_reg;
    logic  dneg1_reg;
    sum_t  nn1_reg;
    logic  zero1_reg;

    comp_t v2_reg [3];
    num_t  num2_reg [3];
    logic  sub2_reg [3];
    sum_t  nn2_reg;
    logic  zero2_reg;

    logic  dneg_next;
    sum_t  dmag_next;
    logic [SW+CW-1:0] prod_next [3];

    assign rdy[2]   = out_ready;
    assign rdy[1]   = ~vld_reg[1] | rdy[2];
    assign rdy[0]   = ~vld_reg[0] | rdy[1];
    assign in_ready = rdy[0];

    always_comb
    begin
        dneg_next = neg > pos;
        dmag_next = dneg_next ? (neg - pos) : (pos - neg);
        for (int i = 0; i < 3; i++)
            prod_next[i] = (SW+CW)'(dmag1_reg) * (SW+CW)'(nm1_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            if (rdy[1])
                vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            v1_reg    <= vec;
            nm1_reg   <= nmag;
            nneg1_reg <= nneg;
            dmag1_reg <= dmag_next;
            dneg1_reg <= dneg_next;
            nn1_reg   <= nn;
            zero1_reg <= (nn == '0);
        end
        if (rdy[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                v2_reg[i]   <= v1_reg[i];
                num2_reg[i] <= {prod_next[i], 1'b0};
                // The quotient is subtracted from v_i when the signs of v.n and n_i agree.
                sub2_reg[i] <= (dneg1_reg == nneg1_reg[i]);
            end
            nn2_reg   <= nn1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    assign out_valid = vld_reg[1];
    assign vec_out   = v2_reg;
    assign num_out   = num2_reg;
    assign sub_out   = sub2_reg;
    assign nn_out    = nn2_reg;
    assign zero_out  = zero2_reg;

endmodule

>>> design/rfl_div.sv
// Pipelined restoring divider for the three lanes: one quotient bit per register stage.
// It divides each numerator by n.n over QW stages and passes the remainder on for rounding.
// It depends on rfl_pkg.
module rfl_div
    import rfl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  comp_t vec [3],
    input  num_t  num [3],
    input  logic  sub [3],
    input  sum_t  nn,
    input  logic  zero,
    output logic  out_valid,
    input  logic  out_ready,
    output comp_t vec_out [3],
    output quot_t quot_out [3],
    output sum_t  rem_out [3],
    output logic  sub_out [3],
    output sum_t  nn_out,
    output logic  zero_out
);

    logic [QW-1:0] vld_reg;
    logic [QW:0]   rdy;

    sum_t  rem_reg  [QW][3];
    quot_t low_reg  [QW][3];
    quot_t q_reg    [QW][3];
    comp_t v_reg    [QW][3];
    logic  sub_reg  [QW][3];
    sum_t  nn_reg   [QW];
    logic  zero_reg [QW];

    sum_t  rem_next [QW][3];
    quot_t low_next [QW][3];
    quot_t q_next   [QW][3];

    logic [SW:0] trial;
    logic        fits;
    sum_t        src_rem;
    quot_t       src_low;
    quot_t       src_q;
    sum_t        src_nn;

    assign in_ready = rdy[0];

    always_comb
    begin
        rdy[QW] = out_ready;
        for (int k = QW - 1; k >= 0; k--)
            rdy[k] = ~vld_reg[k] | rdy[k+1];
    end

    // The quotient fits in QW bits, so the top of the numerator is already below n.n
    // and serves as the starting remainder.
    always_comb
    begin
        trial   = '0;
        fits    = 1'b0;
        src_rem = '0;
        src_low = '0;
        src_q   = '0;
        src_nn  = '0;
        for (int k = 0; k < QW; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (k == 0)
                begin
                    src_rem = num[i][NW-1:QW];
                    src_low = num[i][QW-1:0];
                    src_q   = '0;
                    src_nn  = nn;
                end
                else
                begin
                    src_rem = rem_reg[k-1][i];
                    src_low = low_reg[k-1][i];
                    src_q   = q_reg[k-1][i];
                    src_nn  = nn_reg[k-1];
                end
                trial = {src_rem, src_low[QW-1]};
                fits  = trial >= {1'b0, src_nn};
                rem_next[k][i] = fits ? SW'(trial - {1'b0, src_nn}) : SW'(trial);
                low_next[k][i] = {src_low[QW-2:0], 1'b0};
                q_next[k][i]   = {src_q[QW-2:0], fits};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int k = 0; k < QW; k++)
            begin
                if (rdy[k])
                    vld_reg[k] <= (k == 0) ? in_valid : vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QW; k++)
        begin
            if (rdy[k])
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[k][i] <= rem_next[k][i];
                    low_reg[k][i] <= low_next[k][i];
                    q_reg[k][i]   <= q_next[k][i];
                    v_reg[k][i]   <= (k == 0) ? vec[i] : v_reg[k-1][i];
                    sub_reg[k][i] <= (k == 0) ? sub[i] : sub_reg[k-1][i];
                end
                nn_reg[k]   <= (k == 0) ? nn : nn_reg[k-1];
                zero_reg[k] <= (k == 0) ? zero : zero_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign vec_out   = v_reg[QW-1];
    assign quot_out  = q_reg[QW-1];
    assign rem_out   = rem_reg[QW-1];
    assign sub_out   = sub_reg[QW-1];
    assign nn_out    = nn_reg[QW-1];
    assign zero_out  = zero_reg[QW-1];

endmodule

>>> tb/vector_reflection_checker.sv
// Checker for the vector reflection block: predicts r = v - 2 (v.n) n / (n.n) per item.
// It watches both channels and compares results in order. Depends on rfl_pkg.
module vector_reflection_checker
    import rfl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  comp_t                vec_x,
    input  comp_t                vec_y,
    input  comp_t                vec_z,
    input  comp_t                norm_x,
    input  comp_t                norm_y,
    input  comp_t                norm_z,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic signed [OW-1:0] refl_x,
    input  logic signed [OW-1:0] refl_y,
    input  logic signed [OW-1:0] refl_z,
    input  logic                 zero_normal,
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     REPORT_LIMIT = 10;
    localparam longint OUT_MAX      = (longint'(1) << CW) - 1;
    localparam longint OUT_MIN      = -(longint'(1) << CW);

    typedef struct packed {
        logic signed [OW-1:0] rx;
        logic signed [OW-1:0] ry;
        logic signed [OW-1:0] rz;
        logic                 zn;
    } refl_t;

    refl_t expected_reflections[$];
    refl_t want;

    // Exact integer reflection; the one division is rounded to nearest, ties away from zero.
    function automatic refl_t reflect_about_normal(input comp_t vx, input comp_t vy,
                                                   input comp_t vz, input comp_t nx,
                                                   input comp_t ny, input comp_t nz);
        longint v[3];
        longint n[3];
        longint c[3];
        longint dot;
        longint nn;
        longint num;
        longint q;
        longint rem;
        longint r;
        refl_t  res;
        v[0] = longint'(vx);
        v[1] = longint'(vy);
        v[2] = longint'(vz);
        n[0] = longint'(nx);
        n[1] = longint'(ny);
        n[2] = longint'(nz);
        dot = 0;
        nn  = 0;
        for (int i = 0; i < 3; i++)
        begin
            dot += v[i] * n[i];
            nn  += n[i] * n[i];
        end
        res = '0;
        if (nn == 0)
        begin
            res.zn = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++)
        begin
            num = 2 * (dot < 0 ? -dot : dot) * (n[i] < 0 ? -n[i] : n[i]);
            q   = num / nn;
            rem = num % nn;
            if (2 * rem >= nn)
                q++;
            // The sign of the subtracted term is the sign of (v.n) n_i.
            if ((dot < 0) != (n[i] < 0))
                r = v[i] + q;
            else
                r = v[i] - q;
            if (r > OUT_MAX)
                r = OUT_MAX;
            if (r < OUT_MIN)
                r = OUT_MIN;
            c[i] = r;
        end
        res.rx = OW'(c[0]);
        res.ry = OW'(c[1]);
        res.rz = OW'(c[2]);
        return res;
    endfunction

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Results are registered and never leave in the cycle their item is accepted, so check before queuing.
            if (out_valid && out_ready)
            begin
                if (expected_reflections.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%t: unexpected result x=%0d y=%0d z=%0d zero=%0b", $time,
                                 refl_x, refl_y, refl_z, zero_normal);
                    mismatches++;
                end
                else
                begin
                    want = expected_reflections.pop_front();
                    if (refl_x !== want.rx || refl_y !== want.ry || refl_z !== want.rz ||
                        zero_normal !== want.zn)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display("%t: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                     $time, want.rx, want.ry, want.rz, want.zn,
                                     refl_x, refl_y, refl_z, zero_normal);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_reflections.push_back(
                    reflect_about_normal(vec_x, vec_y, vec_z, norm_x, norm_y, norm_z));
            outstanding = expected_reflections.size();
        end
    end

endmodule

>>> tb/vector_reflection_about_normal_test.sv
// Top of the vector reflection testbench: clock, reset, stimulus, receiver stalls, verdict.
// Depends on rfl_pkg, the block under test and vector_reflection_checker.
module vector_reflection_about_normal_test;
    import rfl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        comp_t vx;
        comp_t vy;
        comp_t vz;
        comp_t nx;
        comp_t ny;
        comp_t nz;
    } vec_pair_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    comp_t                vec_x;
    comp_t                vec_y;
    comp_t                vec_z;
    comp_t                norm_x;
    comp_t                norm_y;
    comp_t                norm_z;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [OW-1:0] refl_x;
    logic signed [OW-1:0] refl_y;
    logic signed [OW-1:0] refl_z;
    logic                 zero_normal;
    int                   mismatches;
    int                   outstanding;

    vector_reflection_about_normal u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .vec_z       (vec_z),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_z      (norm_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .refl_x      (refl_x),
        .refl_y      (refl_y),
        .refl_z      (refl_z),
        .zero_normal (zero_normal)
    );

    vector_reflection_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .vec_z       (vec_z),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_z      (norm_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .refl_x      (refl_x),
        .refl_y      (refl_y),
        .refl_z      (refl_z),
        .zero_normal (zero_normal),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Full-range values half of the time, with small, medium and extreme ones mixed in.
    function automatic comp_t random_comp();
        comp_t c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: c = comp_t'($urandom);
            5, 6:          c = comp_t'(int'($urandom_range(0, 16)) - 8);
            7:
            begin
                case ($urandom_range(0, 4))
                    0:       c = 16'sh7fff;
                    1:       c = 16'sh8000;
                    2:       c = 16'sh0000;
                    3:       c = -16'sd1;
                    default: c = 16'sd1;
                endcase
            end
            default:       c = comp_t'(int'($urandom_range(0, 2000)) - 1000);
        endcase
        return c;
    endfunction

    function automatic vec_pair_t random_pair();
        vec_pair_t p;
        p.vx = random_comp();
        p.vy = random_comp();
        p.vz = random_comp();
        p.nx = random_comp();
        p.ny = random_comp();
        p.nz = random_comp();
        case ($urandom_range(0, 19))
            0:
            begin
                p.nx = '0;
                p.ny = '0;
                p.nz = '0;
            end
            1, 2:
            begin
                // Normal along one axis.
                p.ny = '0;
                p.nz = '0;
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pair(input vec_pair_t p);
        vec_x    = p.vx;
        vec_y    = p.vy;
        vec_z    = p.vz;
        norm_x   = p.nx;
        norm_y   = p.ny;
        norm_z   = p.nz;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: ready in randomly chosen modes that change from block to block.
    initial
    begin
        int mode;
        int cyc;
        out_ready = 1'b0;
        cyc = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat (64)
            begin
                @(negedge clk);
                cyc++;
                case (mode)
                    0:       out_ready = 1'b1;
                    1:       out_ready = ($urandom_range(0, 1) == 1);
                    2:       out_ready = ($urandom_range(0, 3) == 0);
                    default: out_ready = ((cyc % 7) < 4);
                endcase
            end
        end
    end

    // Watchdog: ends the run when no item moves on either channel for too long.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("vector_reflection_about_normal verification failed");
        $finish;
    end

    initial
    begin
        vec_pair_t directed[$];
        int        burst_left;
        int        gap;
        int        total;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        vec_x    = '0;
        vec_y    = '0;
        vec_z    = '0;
        norm_x   = '0;
        norm_y   = '0;
        norm_z   = '0;

        // Zero normal, with zero and extreme vectors.
        directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        directed.push_back({16'sh7fff, 16'sh8000, 16'sd1, 16'sd0, 16'sd0, 16'sd0});
        directed.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd0});
        // Axis normals, unit and of length three.
        directed.push_back({16'sd5, 16'sd6, 16'sd7, 16'sd1, 16'sd0, 16'sd0});
        directed.push_back({16'sd5, 16'sd6, 16'sd7, 16'sd0, -16'sd1, 16'sd0});
        directed.push_back({16'sd5, -16'sd6, 16'sd7, 16'sd0, 16'sd0, 16'sd3});
        // Most negative and full-scale components; some reflections need the extra output bit.
        directed.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0});
        directed.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        directed.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000});
        directed.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        directed.push_back({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff});
        directed.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        // Vector lying in the mirror plane, and vector along the normal.
        directed.push_back({16'sd3, -16'sd3, 16'sd0, 16'sd1, 16'sd1, 16'sd0});
        directed.push_back({16'sd4, 16'sd4, 16'sd4, 16'sd2, 16'sd2, 16'sd2});
        // Quotients with fractional parts above and below one half, and exact ones.
        directed.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1});
        directed.push_back({16'sd2, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1});
        directed.push_back({-16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1});
        directed.push_back({-16'sd2, 16'sd0, 16'sd0, -16'sd1, 16'sd1, -16'sd1});
        directed.push_back({16'sd1, 16'sd2, 16'sd3, 16'sd1, 16'sd2, 16'sd3});
        directed.push_back({16'sd7, -16'sd5, 16'sd1, 16'sd3, 16'sd1, -16'sd2});
        // Tiny normal against a full-scale vector, and the reverse.
        directed.push_back({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sd1, 16'sd1, 16'sd0});
        directed.push_back({16'sd1, -16'sd1, 16'sd0, 16'sh8000, 16'sh7fff, 16'sd1});

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        total      = directed.size() + RANDOM_ITEMS;
        burst_left = 0;
        for (int k = 0; k < total; k++)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    in_valid = 1'b0;
                    repeat (gap)
                        @(negedge clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 16);
            end
            if (k < directed.size())
                send_pair(directed[k]);
            else
                send_pair(random_pair());
            burst_left--;
        end
        in_valid = 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("vector_reflection_about_normal verification clean");
        else
            $display("vector_reflection_about_normal verification failed");
        $finish;
    end

endmodule

>>> sim.f
design/rfl_pkg.sv
design/rfl_dot.sv
design/rfl_scale.sv
design/rfl_div.sv
design/vector_reflection_about_normal.sv
tb/vector_reflection_checker.sv
tb/vector_reflection_about_normal_test.sv
